FILE: sv/tdcl_pkg.sv
// Shared types, curve tables and widths for the temperature-derated current limits.
`timescale 1ns / 1ps
`default_nettype none

package tdcl_pkg;

    // Field and datapath widths
    localparam int TEMP_W           = 15;
    localparam int CHG_W            = 12;
    localparam int DIS_W            = 15;
    localparam int KNOT_W           = 16;
    localparam int QUOT_W           = 16;
    localparam int NUM_W            = 2 * KNOT_W + 2;
    localparam int S_DATA_W         = 16;
    localparam int M_DATA_W         = 32;
    localparam int M_PAD_W          = M_DATA_W - CHG_W - DIS_W;
    localparam int LANES            = 2;
    localparam int LANE_CHG         = 0;
    localparam int LANE_DIS         = 1;

    // Curve geometry
    localparam int CURVE_POINTS_DEF = 13;
    localparam int ROM_POINTS       = 13;
    localparam int ROM_IDX_W        = $clog2(ROM_POINTS);
    localparam int IDX_MAX_W        = 5;

    typedef logic signed [KNOT_W-1:0] t_knot;

    // Knot temperatures, shared by both curves (centi-degrees)
    localparam t_knot KNOT_TEMP [ROM_POINTS] = '{
        16'sd0,    16'sd500,  16'sd1000, 16'sd1500, 16'sd2000, 16'sd2500, 16'sd3000,
        16'sd3500, 16'sd4000, 16'sd4500, 16'sd5000, 16'sd5500, 16'sd6000
    };

    // Charge curve currents (centi-amperes)
    localparam t_knot CHG_AMPS [ROM_POINTS] = '{
        16'sd0,    16'sd0,    16'sd1000, 16'sd2000, 16'sd3000, 16'sd3000, 16'sd3000,
        16'sd3000, 16'sd2000, 16'sd1000, 16'sd500,  16'sd0,    16'sd0
    };

    // Discharge curve currents (centi-amperes)
    localparam t_knot DIS_AMPS [ROM_POINTS] = '{
        16'sd0,     16'sd4000,  16'sd10000, 16'sd18000, 16'sd18000, 16'sd18000,
        16'sd18000, 16'sd18000, 16'sd18000, 16'sd18000, 16'sd7000,  16'sd1000,
        16'sd0
    };

    // Knot temperature; points past the ROM read as zero
    function automatic t_knot knot_temp(input logic [IDX_MAX_W-1:0] idx);
        t_knot v;
        v = '0;
        if (idx < IDX_MAX_W'(ROM_POINTS)) begin
            v = KNOT_TEMP[idx[ROM_IDX_W-1:0]];
        end
        return v;
    endfunction

    // Knot current of one curve; points past the ROM read as zero
    function automatic t_knot knot_amps(input logic lane, input logic [IDX_MAX_W-1:0] idx);
        t_knot v;
        v = '0;
        if (idx < IDX_MAX_W'(ROM_POINTS)) begin
            v = lane ? DIS_AMPS[idx[ROM_IDX_W-1:0]] : CHG_AMPS[idx[ROM_IDX_W-1:0]];
        end
        return v;
    endfunction

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_MUL,
        S_SUM,
        S_DIV,
        S_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic clamp;
        logic step_idx;
        logic mul;
        logic sum;
        logic div_step;
        logic emit;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic lo_clamp;
        logic hi_clamp;
        logic seg_found;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: sv/tdcl_div.sv
// Restoring divider lane: one quotient bit per step, with a bypass load.
`timescale 1ns / 1ps
`default_nettype none

module tdcl_div
    import tdcl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_step,
    input  wire logic              i_bypass,
    input  wire logic [QUOT_W-1:0] i_bypass_val,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [KNOT_W-1:0] i_dvs,
    output logic      [QUOT_W-1:0] o_quot,
    output logic                   o_busy
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [CNT_W-1:0]  r_left;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  n_rem;
    logic [NUM_W-1:0]  r_dvs;
    logic [QUOT_W-1:0] r_quot;
    logic              w_ge;

    assign o_busy = (r_left != '0);
    assign o_quot = r_quot;

    // Trial subtract of the shifted divisor
    always_comb begin
        w_ge  = (r_rem >= r_dvs);
        n_rem = w_ge ? (r_rem - r_dvs) : r_rem;
    end

    // Count remaining steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_start) begin
            r_left <= i_bypass ? '0 : CNT_W'(QUOT_W);
        end else if (i_step && o_busy) begin
            r_left <= r_left - 1'b1;
        end
    end

    // Advance remainder, divisor and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dvs  <= NUM_W'({i_dvs, {(QUOT_W-1){1'b0}}});
            r_quot <= i_bypass ? i_bypass_val : '0;
        end else if (i_step && o_busy) begin
            r_rem  <= n_rem;
            r_dvs  <= r_dvs >> 1;
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

FILE: sv/tdcl_dp.sv
// Datapath: segment search, interpolation products, divider lanes and output register.
`timescale 1ns / 1ps
`default_nettype none

module tdcl_dp
    import tdcl_pkg::*;
#(
    parameter int CURVE_POINTS = CURVE_POINTS_DEF
)(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic signed [TEMP_W-1:0] i_temp,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_stat                      o_stat,
    output logic                          o_m_valid,
    input  wire logic                     i_m_ready,
    output logic             [CHG_W-1:0]  o_chg,
    output logic             [DIS_W-1:0]  o_dis
);

    localparam int IDX_W = $clog2(CURVE_POINTS);
    localparam logic [IDX_MAX_W-1:0] IDX_LAST = IDX_MAX_W'(CURVE_POINTS - 1);

    logic signed [TEMP_W-1:0]   r_temp;
    logic        [IDX_W-1:0]    r_idx;
    logic signed [KNOT_W:0]     r_span;
    logic signed [NUM_W-1:0]    r_p_y0 [LANES];
    logic signed [NUM_W-1:0]    r_p_dy [LANES];
    t_knot                      r_y0   [LANES];
    logic                       r_out_valid;
    logic        [CHG_W-1:0]    r_chg;
    logic        [DIS_W-1:0]    r_dis;

    t_knot                      w_t;
    logic        [IDX_MAX_W-1:0] w_idx_lo;
    logic        [IDX_MAX_W-1:0] w_idx_hi;
    t_knot                      w_x0;
    t_knot                      w_x1;
    t_knot                      w_xf;
    t_knot                      w_xl;
    logic                       w_lo_clamp;
    logic                       w_hi_clamp;
    logic signed [KNOT_W:0]     w_dx;
    logic signed [KNOT_W:0]     w_span;
    logic                       w_span_bad;
    t_knot                      w_y0   [LANES];
    t_knot                      w_y1   [LANES];
    t_knot                      w_yf   [LANES];
    t_knot                      w_yl   [LANES];
    logic signed [KNOT_W:0]     w_dy   [LANES];
    logic signed [KNOT_W:0]     w_y0x  [LANES];
    logic signed [NUM_W-1:0]    w_p_y0 [LANES];
    logic signed [NUM_W-1:0]    w_p_dy [LANES];
    logic signed [NUM_W:0]      w_num  [LANES];
    logic                       w_start;
    logic        [LANES-1:0]    w_bypass;
    logic        [QUOT_W-1:0]   w_byp_val [LANES];
    logic        [QUOT_W-1:0]   w_quot    [LANES];
    logic        [LANES-1:0]    w_busy;

    // Segment end points and clamp tests
    always_comb begin
        w_t        = KNOT_W'(r_temp);
        w_idx_lo   = IDX_MAX_W'(r_idx);
        w_idx_hi   = w_idx_lo + 1'b1;
        w_x0       = knot_temp(w_idx_lo);
        w_x1       = knot_temp(w_idx_hi);
        w_xf       = knot_temp('0);
        w_xl       = knot_temp(IDX_LAST);
        w_lo_clamp = (w_t <= w_xf);
        w_hi_clamp = (w_t >= w_xl);
        w_dx       = (KNOT_W+1)'(w_t) - (KNOT_W+1)'(w_x0);
        w_span     = (KNOT_W+1)'(w_x1) - (KNOT_W+1)'(w_x0);
        w_span_bad = r_span[KNOT_W] || (r_span == '0);
    end

    // Per-curve products, numerator and divider set-up
    always_comb begin
        w_start = i_cmd.clamp || i_cmd.sum;
        for (int l = 0; l < LANES; l++) begin
            w_y0[l]   = knot_amps(1'(l), w_idx_lo);
            w_y1[l]   = knot_amps(1'(l), w_idx_hi);
            w_yf[l]   = knot_amps(1'(l), '0);
            w_yl[l]   = knot_amps(1'(l), IDX_LAST);
            w_dy[l]   = (KNOT_W+1)'(w_y1[l]) - (KNOT_W+1)'(w_y0[l]);
            w_y0x[l]  = (KNOT_W+1)'(w_y0[l]);
            w_p_dy[l] = NUM_W'(w_dx) * NUM_W'(w_dy[l]);
            w_p_y0[l] = NUM_W'(w_y0x[l]) * NUM_W'(w_span);
            w_num[l]  = (NUM_W+1)'(r_p_y0[l]) + (NUM_W+1)'(r_p_dy[l]);
            if (i_cmd.clamp) begin
                w_bypass[l]  = 1'b1;
                w_byp_val[l] = w_lo_clamp ? QUOT_W'(w_yf[l]) : QUOT_W'(w_yl[l]);
            end else if (w_span_bad) begin
                w_bypass[l]  = 1'b1;
                w_byp_val[l] = QUOT_W'(r_y0[l]);
            end else begin
                w_bypass[l]  = w_num[l][NUM_W];
                w_byp_val[l] = '0;
            end
        end
    end

    // Hold the sample and walk the segment index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.step_idx) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_temp <= i_temp;
        end
    end

    // Register products of the bracketing segment
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_span <= w_span;
            for (int l = 0; l < LANES; l++) begin
                r_p_y0[l] <= w_p_y0[l];
                r_p_dy[l] <= w_p_dy[l];
                r_y0[l]   <= w_y0[l];
            end
        end
    end

    // Divider lanes, one per curve
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        tdcl_div u_div (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_start      (w_start),
            .i_step       (i_cmd.div_step),
            .i_bypass     (w_bypass[l]),
            .i_bypass_val (w_byp_val[l]),
            .i_num        (w_num[l][NUM_W-1:0]),
            .i_dvs        (r_span[KNOT_W-1:0]),
            .o_quot       (w_quot[l]),
            .o_busy       (w_busy[l])
        );
    end

    // Output register: load on emit, drop on transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_chg <= CHG_W'(w_quot[LANE_CHG]);
            r_dis <= DIS_W'(w_quot[LANE_DIS]);
        end
    end

    assign o_m_valid        = r_out_valid;
    assign o_chg            = r_chg;
    assign o_dis            = r_dis;
    assign o_stat.lo_clamp  = w_lo_clamp;
    assign o_stat.hi_clamp  = w_hi_clamp;
    assign o_stat.seg_found = (w_t < w_x1);
    assign o_stat.div_done  = (w_busy == '0);
    assign o_stat.out_free  = !r_out_valid || i_m_ready;

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_m_ready))
        else $error("result register overwritten");

    // Search never steps past the last segment
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step_idx |-> (w_idx_hi < IDX_LAST))
        else $error("segment search ran off the curve");

    // Dividers have finished when a result is loaded into the output register
    a_div_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (w_busy == '0))
        else $error("result emitted while dividing");

    // Interpolation only for samples inside the curve
    a_no_clamp_interp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sum |-> (!w_lo_clamp && !w_hi_clamp))
        else $error("interpolating a clamped sample");

endmodule

`default_nettype wire

FILE: sv/tdcl_ctrl.sv
// Controller: sequences acceptance, clamp check, search, multiply, sum, divide and output.
`timescale 1ns / 1ps
`default_nettype none

module tdcl_ctrl
    import tdcl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_valid,
    output logic          o_s_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.lo_clamp || i_stat.hi_clamp) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_stat.seg_found) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.load = i_s_valid;
            end
            S_CHECK: begin
                o_cmd.clamp = i_stat.lo_clamp || i_stat.hi_clamp;
            end
            S_SEARCH: begin
                o_cmd.step_idx = !i_stat.seg_found;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_OUT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/temp_derated_current_limits.sv
// Top level: charge and discharge current limits derated from cell temperature.
//
// Usage:
//   s_axis carries one transaction per temperature sample (signed, centi-degrees).
//   m_axis returns one transaction per sample with the charge and discharge limits
//   (centi-amperes), read off two fixed piecewise-linear curves and clamped to the
//   end points outside the curve.
//   A clamped sample skips the search, multiply and divide; for any other sample
//   the segment search steps one curve point per cycle and the two divider lanes
//   take one quotient bit per cycle for 16 bits.
//   One sample is in flight at a time; the next can be taken in the cycle after the
//   result has been loaded into the output register.
//   The output register holds a finished result until m_axis_tready; the next
//   sample may be accepted and worked on meanwhile, and its result waits until
//   the register is free.
//   Reset (synchronous, active low) empties the output register, returns the
//   controller to idle and clears the segment index and divider step counts.
`timescale 1ns / 1ps
`default_nettype none

module temp_derated_current_limits
    import tdcl_pkg::*;
#(
    parameter int CURVE_POINTS = CURVE_POINTS_DEF
)(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // [14:0] temperature
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic      [M_DATA_W-1:0] m_axis_tdata   // [11:0] charge_limit, [26:12] discharge_limit
);

    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    logic [CHG_W-1:0] w_chg;
    logic [DIS_W-1:0] w_dis;

    tdcl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    tdcl_dp #(
        .CURVE_POINTS (CURVE_POINTS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_temp    (s_axis_tdata[TEMP_W-1:0]),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_chg     (w_chg),
        .o_dis     (w_dis)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tdata = {{M_PAD_W{1'b0}}, w_dis, w_chg};

endmodule

`default_nettype wire

FILE: bench/limits_checker.sv
// Checker that predicts and compares the derated charge and discharge limits.
`timescale 1ns / 1ps

module limits_checker
    import tdcl_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    input  wire logic                s_axis_tready,
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // [14:0] temperature
    input  wire logic                m_axis_tvalid,
    input  wire logic                m_axis_tready,
    input  wire logic [M_DATA_W-1:0] m_axis_tdata,  // [11:0] charge_limit, [26:12] discharge_limit
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int POINTS = 13;

    // Derating curves: temperature in centi-degrees, current in centi-amperes
    localparam int TEMP_PT [POINTS] = '{
        0, 500, 1000, 1500, 2000, 2500, 3000, 3500, 4000, 4500, 5000, 5500, 6000
    };
    localparam int CHARGE_PT [POINTS] = '{
        0, 0, 1000, 2000, 3000, 3000, 3000, 3000, 2000, 1000, 500, 0, 0
    };
    localparam int DISCHARGE_PT [POINTS] = '{
        0, 4000, 10000, 18000, 18000, 18000, 18000, 18000, 18000, 18000, 7000, 1000, 0
    };

    typedef struct {
        logic [CHG_W-1:0] charge;
        logic [DIS_W-1:0] discharge;
    } limits_t;

    limits_t due_limits [$];
    limits_t want;
    int      mismatches = 0;

    // Current of one curve point
    function automatic longint curve_amps(input bit discharge, input int k);
        return discharge ? DISCHARGE_PT[k] : CHARGE_PT[k];
    endfunction

    // Clamp at the ends, otherwise interpolate on the bracketing segment and truncate
    function automatic longint derated_limit(input logic signed [TEMP_W-1:0] temp,
                                             input bit discharge);
        int     t;
        longint span;
        longint num;
        t = temp;
        if (t <= TEMP_PT[0]) return curve_amps(discharge, 0);
        if (t >= TEMP_PT[POINTS-1]) return curve_amps(discharge, POINTS - 1);
        for (int k = 0; k < POINTS - 1; k++) begin
            if (t < TEMP_PT[k+1]) begin
                span = TEMP_PT[k+1] - TEMP_PT[k];
                num  = curve_amps(discharge, k) * span
                     + longint'(t - TEMP_PT[k])
                       * (curve_amps(discharge, k + 1) - curve_amps(discharge, k));
                if (num < 0) return 0;
                return num / span;
            end
        end
        return 0;
    endfunction

    function automatic limits_t predict_limits(input logic signed [TEMP_W-1:0] temp);
        limits_t lim;
        lim.charge    = CHG_W'(derated_limit(temp, 1'b0));
        lim.discharge = DIS_W'(derated_limit(temp, 1'b1));
        return lim;
    endfunction

    // Compare each result transaction, then queue the prediction for each sample
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_limits.size() == 0) begin
                    $error("result with no sample pending: tdata=%h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = due_limits.pop_front();
                    if (m_axis_tdata[CHG_W-1:0] !== want.charge) begin
                        $error("charge_limit: expected %0d, actual %0d",
                               want.charge, m_axis_tdata[CHG_W-1:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[CHG_W +: DIS_W] !== want.discharge) begin
                        $error("discharge_limit: expected %0d, actual %0d",
                               want.discharge, m_axis_tdata[CHG_W +: DIS_W]);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                due_limits.push_back(predict_limits(s_axis_tdata[TEMP_W-1:0]));
            end
        end
        o_pending    <= due_limits.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: bench/tb_top.sv
// Testbench top: temperature stimulus, result sink, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;
    import tdcl_pkg::*;

    localparam int RANDOM_SAMPLES = 1425;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int LONG_HOLD      = 500;

    // Clamps, knots, neighbors of knots and the extremes of the 15-bit field
    localparam int CORNER_TEMPS [25] = '{
        -16384, 16383, -4000, 15000, -1, 0, 1, 499, 500, 750, 1000, 1250, 1500,
        2000, 3500, 3999, 4000, 4333, 4500, 5000, 5001, 5500, 5999, 6000, 6001
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;   // [14:0] temperature
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;   // [11:0] charge_limit, [26:12] discharge_limit
    int                  fail_count;
    int                  pending;
    int                  samples_sent = 0;
    int                  idle_cycles  = 0;

    temp_derated_current_limits uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    limits_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offer one sample after a random gap and hold it until accepted
    task automatic send_temperature(input logic signed [TEMP_W-1:0] temp);
        int gap;
        gap = ((samples_sent / 120) % 3 == 2) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W - TEMP_W){1'b0}}, temp};
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
    endtask

    // Mostly interpolating samples, then knots, the stated range and any pattern
    function automatic logic signed [TEMP_W-1:0] random_temperature();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            v = $urandom_range(0, 6000);
        end else if (pick < 70) begin
            v = 500 * int'($urandom_range(0, 12)) + int'($urandom_range(0, 2)) - 1;
        end else if (pick < 85) begin
            v = int'($urandom_range(0, 19000)) - 4000;
        end else begin
            v = $urandom;
        end
        return TEMP_W'(v);
    endfunction

    // Drive reset, the corner samples, the random samples, then drain and judge
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (CORNER_TEMPS[k]) begin
            send_temperature(TEMP_W'(CORNER_TEMPS[k]));
        end
        repeat (RANDOM_SAMPLES) send_temperature(random_temperature());
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Take results after random stalls; once, hold off long enough to back up the input
    initial begin : result_sink
        int  stall;
        int  taken;
        bit  held;
        taken = 0;
        held  = 1'b0;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held && taken == 300) begin
                held  = 1'b1;
                stall = LONG_HOLD;
            end else begin
                stall = ((taken / 150) % 3 == 1) ? 0 : $urandom_range(0, 9);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    // Abort when no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
